// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file cdq_checker.sv.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on this edge.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cdq_pkg.sv
package cdq_pkg;

	localparam int CDQ_DEPTH = 16;

	localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [2:0] ACT_POP_BACK   = 3'd3;
	localparam logic [2:0] ACT_SEARCH     = 3'd4;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] item_value;
	} cdq_req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic               found;
		logic [3:0]         position;
		logic [4:0]         element_count;
	} cdq_rsp_t;

endpackage

// File: rtl/core/cdq_ram.sv
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port; registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// File: rtl/core/circular_deque_with_search.sv
// Channel | Direction | Handshake           | Beat payload
// req     | in        | req_valid/req_ready | cdq_req_t: action, item_value
// rsp     | out       | rsp_valid/rsp_ready | cdq_rsp_t: status, out_value, found,
//         |           |                     |   position, element_count
//
// Per item, accept to next accept: push, refused pop, empty search or no-op go to
// S_DONE; a pop passes S_READ for the registered read of the ring RAM; a search
// compares one entry per RAM read in S_SCAN (1..count entries). The output register
// loads when free or ready is high. Reset clears front index, count and control.
// Stalls: RAM contents stay undefined after reset; a waiting result does not block
// the next accept, and a finished item holds until the output register is free.
module circular_deque_with_search
	import cdq_pkg::*;
#(
	parameter int DEPTH = CDQ_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  cdq_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output cdq_rsp_t rsp
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// One-hot sequencer: accept, read wait, scan, hand off result.
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_SCAN = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t            state_q, state_n;
	logic [IDX_W-1:0]  front_q, front_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [IDX_W-1:0]  rd_ptr_q, rd_ptr_n;
	logic [IDX_W-1:0]  scan_k_q, scan_k_n;
	logic [31:0]       val_q, val_n;
	cdq_rsp_t          res_q, res_n;
	logic              out_valid_q;
	cdq_rsp_t          out_q;
	logic              out_load;

	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [31:0]       wr_data;
	logic [IDX_W-1:0]  rd_addr;
	logic [31:0]       rd_data;

	logic              full, empty, scan_last;
	logic [IDX_W-1:0]  front_dec, back_slot, last_slot;

	// Add an offset below DEPTH to a ring slot, wrapping once.
	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
						       input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W + 1)'(DEPTH)) begin
			sum = sum - (IDX_W + 1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

	cdq_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

	// Slot ahead of the front, slot past the back, slot of the back element.
	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - IDX_W'(1);
	assign back_slot = ring_add(front_q, count_q[IDX_W-1:0]);
	assign last_slot = ring_add(front_q, IDX_W'(count_q - CNT_W'(1)));

	// The entry compared now is the last element held.
	assign scan_last = ((CNT_W'(scan_k_q) + CNT_W'(1)) == count_q);

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	always_comb begin
		state_n  = state_q;
		front_n  = front_q;
		count_n  = count_q;
		rd_ptr_n = rd_ptr_q;
		scan_k_n = scan_k_q;
		val_n    = val_q;
		res_n    = res_q;
		wr_en    = 1'b0;
		wr_addr  = back_slot;
		wr_data  = req.item_value;
		rd_addr  = rd_ptr_q;
		out_load = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					// Start a fresh result; pointers and count move right here,
					// so the element count in the result is the one after this beat.
					res_n   = '0;
					val_n   = req.item_value;
					state_n = S_DONE;
					case (req.action)
						ACT_PUSH_FRONT: begin
							if (full) begin
								res_n.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = front_dec;
								front_n = front_dec;
								count_n = count_q + CNT_W'(1);
							end
						end
						ACT_PUSH_BACK: begin
							if (full) begin
								res_n.status = ST_FULL;
							end else begin
								wr_en   = 1'b1;
								wr_addr = back_slot;
								count_n = count_q + CNT_W'(1);
							end
						end
						ACT_POP_FRONT: begin
							if (empty) begin
								res_n.status = ST_EMPTY;
							end else begin
								rd_addr = front_q;
								front_n = ring_add(front_q, IDX_W'(1));
								count_n = count_q - CNT_W'(1);
								state_n = S_READ;
							end
						end
						ACT_POP_BACK: begin
							if (empty) begin
								res_n.status = ST_EMPTY;
							end else begin
								rd_addr = last_slot;
								count_n = count_q - CNT_W'(1);
								state_n = S_READ;
							end
						end
						ACT_SEARCH: begin
							// Issue the read of the front entry; the scan compares
							// one entry per cycle while the next read is in flight.
							if (!empty) begin
								rd_addr  = front_q;
								rd_ptr_n = ring_add(front_q, IDX_W'(1));
								scan_k_n = '0;
								state_n  = S_SCAN;
							end
						end
						default: begin
						end
					endcase
					res_n.element_count = 5'(count_n);
				end
			end
			S_READ: begin
				// RAM data for the popped slot arrives now.
				res_n.out_value = rd_data;
				state_n         = S_DONE;
			end
			S_SCAN: begin
				// Compare the entry read last cycle, advance the read pointer.
				rd_addr  = rd_ptr_q;
				rd_ptr_n = ring_add(rd_ptr_q, IDX_W'(1));
				scan_k_n = scan_k_q + IDX_W'(1);
				if (rd_data == val_q) begin
					res_n.found    = 1'b1;
					res_n.position = 4'(scan_k_q);
					state_n        = S_DONE;
				end else if (scan_last) begin
					state_n = S_DONE;
				end
			end
			S_DONE: begin
				// Hold the result until the output register is free.
				if (!out_valid_q || rsp_ready) begin
					out_load = 1'b1;
					state_n  = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			front_q <= front_n;
			count_q <= count_n;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers and output payload carry no reset.
	always_ff @(posedge clk) begin
		rd_ptr_q <= rd_ptr_n;
		scan_k_q <= scan_k_n;
		val_q    <= val_n;
		res_q    <= res_n;
		if (out_load) begin
			out_q <= res_q;
		end
	end

endmodule

// File: rtl/core/cdq_checker.sv
`include "assert_macros.svh"

module cdq_checker
	import cdq_pkg::*;
#(
	parameter int DEPTH = CDQ_DEPTH
) (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input cdq_rsp_t rsp
);

	// Hold a stalled result beat.
	`ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "rsp beat dropped or changed while stalled")

	// One item at a time: ready drops after every accepted beat.
	`ASSERT_NXT(a_one_item, req_valid && req_ready, !req_ready, "req accepted while an item is at work")

	// A refused push reports a full list.
	`ASSERT_IMP(a_full_count, rsp_valid && rsp.status == ST_FULL, (DEPTH > 16) || (rsp.element_count == 5'(DEPTH)), "full status with list not full")

	// A refused pop reports an empty list.
	`ASSERT_IMP(a_empty_count, rsp_valid && rsp.status == ST_EMPTY, rsp.element_count == 5'd0, "empty status with elements held")

	// A hit comes only from a completed search, with nothing popped.
	`ASSERT_IMP(a_found_clean, rsp_valid && rsp.found, rsp.status == ST_DONE && rsp.out_value == 32'sd0, "search hit with status or value set")

endmodule

bind circular_deque_with_search cdq_checker #(
	.DEPTH (DEPTH)
) u_cdq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

// File: sim/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	// Action codes the block treats as a no-op.
	localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
	localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

	// Long receiver hold-off, in cycles, used to back the block up.
	localparam int RSP_HOLD_CYCLES = 300;
	// Cycles with no beat on either channel before the run is called hung.
	localparam int STALL_LIMIT = 2000;
	// Random beats per phase; six phases plus the directed opening.
	localparam int PHASE_BEATS = 154;
	localparam int PHASE_COUNT = 6;

	// Mirror of the deque contents plus the queue of results still owed.
	class deque_tracker;
		logic [31:0] ring [CDQ_DEPTH];
		int unsigned head;
		int unsigned held;
		cdq_rsp_t owed_results[$];
		int unsigned errors;

		function new();
			head = 0;
			held = 0;
			errors = 0;
		endfunction

		function logic [31:0] held_value(int unsigned k);
			return ring[(head + k) % CDQ_DEPTH];
		endfunction

		// Advance the mirror by one accepted request and queue its result.
		function void note_request(cdq_req_t item);
			cdq_rsp_t r;
			r = '0;
			case (item.action)
				ACT_PUSH_FRONT: begin
					if (held >= CDQ_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						head = (head + CDQ_DEPTH - 1) % CDQ_DEPTH;
						ring[head] = item.item_value;
						held++;
					end
				end
				ACT_PUSH_BACK: begin
					if (held >= CDQ_DEPTH) begin
						r.status = ST_FULL;
					end else begin
						ring[(head + held) % CDQ_DEPTH] = item.item_value;
						held++;
					end
				end
				ACT_POP_FRONT: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.out_value = ring[head];
						head = (head + 1) % CDQ_DEPTH;
						held--;
					end
				end
				ACT_POP_BACK: begin
					if (held == 0) begin
						r.status = ST_EMPTY;
					end else begin
						r.out_value = held_value(held - 1);
						held--;
					end
				end
				ACT_SEARCH: begin
					for (int k = 0; k < held; k++) begin
						if (held_value(k) == item.item_value) begin
							r.found = 1'b1;
							r.position = 4'(k);
							break;
						end
					end
				end
				default: ;
			endcase
			r.element_count = 5'(held);
			owed_results.push_back(r);
		endfunction

		function void mismatch(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(cdq_rsp_t got);
			cdq_rsp_t want;
			if (owed_results.size() == 0) begin
				$display("%0t: result with nothing expected, expected none, actual %p",
					$time, got);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (got.status !== want.status)
				mismatch("status", 32'(want.status), 32'(got.status));
			if (got.out_value !== want.out_value)
				mismatch("out_value", want.out_value, got.out_value);
			if (got.found !== want.found)
				mismatch("found", 32'(want.found), 32'(got.found));
			if (got.position !== want.position)
				mismatch("position", 32'(want.position), 32'(got.position));
			if (got.element_count !== want.element_count)
				mismatch("element_count", 32'(want.element_count),
					32'(got.element_count));
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     req_valid;
	logic     req_ready;
	cdq_req_t req;
	logic     rsp_valid;
	logic     rsp_ready;
	cdq_rsp_t rsp;

	deque_tracker tracker;

	// Per-side idle ceilings, changed by phase; zero gives back-to-back beats.
	int max_req_gap;
	int max_rsp_gap;
	// Set by the stimulus to make the receiver hold off once, for that many cycles.
	int rsp_hold_request;
	int idle_cycles;

	circular_deque_with_search DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic cdq_req_t beat(logic [2:0] action, logic [31:0] value);
		cdq_req_t b;
		b.action = action;
		b.item_value = value;
		return b;
	endfunction

	// Mix a few repeated small values (so searches hit and duplicates exist),
	// the sign and width extremes, and fully random words.
	function automatic logic [31:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll < 4)
			return 32'($urandom_range(0, 5));
		if (roll == 4) begin
			case ($urandom_range(0, 3))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return 32'h0000_0000;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		return $urandom;
	endfunction

	// Draw one request; push_pct steers the fill level toward full or empty.
	function automatic cdq_req_t random_request(int unsigned push_pct);
		int unsigned roll;
		logic [2:0] act;
		logic [31:0] val;
		roll = $urandom_range(0, 99);
		val = pick_value();
		if (roll < 4) begin
			act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
		end else if (roll < 26) begin
			act = ACT_SEARCH;
			// Half the searches look for something that is really held.
			if (tracker.held > 0 && $urandom_range(0, 1))
				val = tracker.held_value($urandom_range(0, tracker.held - 1));
		end else if ($urandom_range(0, 99) < push_pct) begin
			act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
		end else begin
			act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
		end
		return beat(act, val);
	endfunction

	// Offer one beat after a random gap and hold it until accepted.
	// Entered and left at a falling edge.
	task automatic send_request(cdq_req_t item);
		int gap;
		gap = $urandom_range(0, max_req_gap);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!(req_valid && req_ready));
		tracker.note_request(item);
		@(negedge clk);
	endtask

	// Drop valid and wait for the block to hand back everything it owes.
	task automatic drain_results();
		req_valid <= 1'b0;
		while (tracker.owed_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_directed();
		// Refused pops and a search on an empty deque.
		send_request(beat(ACT_POP_FRONT, 32'h0000_0000));
		send_request(beat(ACT_POP_BACK, 32'h5A5A_5A5A));
		send_request(beat(ACT_SEARCH, 32'h0000_0000));
		// No-op action codes.
		send_request(beat(ACT_UNUSED_LO, 32'hFFFF_FFFF));
		send_request(beat(ACT_UNUSED_HI, 32'h1234_5678));
		// Fill to the brim from both ends, extremes first.
		send_request(beat(ACT_PUSH_FRONT, 32'h8000_0000));
		send_request(beat(ACT_PUSH_BACK, 32'h7FFF_FFFF));
		for (int i = 0; i < CDQ_DEPTH - 2; i++) begin
			send_request(beat(i[0] ? ACT_PUSH_FRONT : ACT_PUSH_BACK,
				(i == 0) ? 32'h0000_0000 : (i == 1) ? 32'hFFFF_FFFF : $urandom));
		end
		// Pushes on a full deque are refused at either end.
		send_request(beat(ACT_PUSH_FRONT, 32'hDEAD_0001));
		send_request(beat(ACT_PUSH_BACK, 32'hDEAD_0002));
		// The tail element sits at the deepest position.
		send_request(beat(ACT_SEARCH, tracker.held_value(CDQ_DEPTH - 1)));
		send_request(beat(ACT_POP_FRONT, 32'h0000_0000));
		send_request(beat(ACT_POP_BACK, 32'h0000_0000));
	endtask

	// Receiver: random stall before each beat, or one long hold-off on request.
	initial begin
		int gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_hold_request > 0) begin
				gap = rsp_hold_request;
				rsp_hold_request = 0;
			end else begin
				gap = $urandom_range(0, max_rsp_gap);
			end
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!(rsp_valid && rsp_ready));
			tracker.check_result(rsp);
			@(negedge clk);
		end
	end

	// Watchdog: count cycles in which neither channel moves a beat.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
				$display("FAIL circular_deque_with_search");
				$finish;
			end
		end
	end

	initial begin
		int unsigned push_pct;
		tracker = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_ready = 1'b0;
		max_req_gap = 6;
		max_rsp_gap = 6;
		rsp_hold_request = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		run_directed();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			// Phase plan: balanced, no idling at all, push-heavy behind a long
			// receiver hold-off, pop-heavy with a busy sender, a clean restart
			// after a full drain, and a final balanced mix.
			case (p)
				0: begin push_pct = 50; max_req_gap = 6; max_rsp_gap = 6; end
				1: begin push_pct = 55; max_req_gap = 0; max_rsp_gap = 0; end
				2: begin
					push_pct = 75; max_req_gap = 0; max_rsp_gap = 6;
					rsp_hold_request = RSP_HOLD_CYCLES;
				end
				3: begin push_pct = 25; max_req_gap = 0; max_rsp_gap = 6; end
				4: begin
					push_pct = 60; max_req_gap = 6; max_rsp_gap = 0;
					drain_results();
				end
				default: begin push_pct = 45; max_req_gap = 6; max_rsp_gap = 6; end
			endcase
			repeat (PHASE_BEATS) send_request(random_request(push_pct));
		end

		// Let the last results come home, then give the block its full search
		// latency to show any stray beat.
		req_valid <= 1'b0;
		while (tracker.owed_results.size() != 0)
			@(posedge clk);
		repeat (CDQ_DEPTH + 8) @(posedge clk);

		if (tracker.errors == 0)
			$display("PASS circular_deque_with_search");
		else
			$display("FAIL circular_deque_with_search");
		$finish;
	end

endmodule
